FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: sv/irpd_pkg.sv
package irpd_pkg;

  localparam int BITS_PER_ITEM = 8;
  localparam int DATA_W        = 8;
  localparam int DUR_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);
  localparam int BIT_CNT_W     = (BITS_PER_ITEM > 1) ? $clog2(BITS_PER_ITEM) : 1;

  localparam logic [DUR_W-1:0] HEADER_MARK_RST  = 16'd3650;
  localparam logic [DUR_W-1:0] HEADER_SPACE_RST = 16'd1623;
  localparam logic [DUR_W-1:0] ONE_MARK_RST     = 16'd428;
  localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 16'd1280;
  localparam logic [DUR_W-1:0] ZERO_MARK_RST    = 16'd428;
  localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = 16'd428;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_ONE_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_MARK    = 3'd4,
    REG_ZERO_SPACE   = 3'd5
  } irpd_reg_t;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark;
    logic [DUR_W-1:0] header_space;
    logic [DUR_W-1:0] one_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] zero_mark;
    logic [DUR_W-1:0] zero_space;
  } irpd_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              first;
    logic              last;
  } irpd_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } irpd_q_status_t;

  typedef struct packed {
    logic emit;
    logic last_pulse;
  } irpd_seq_status_t;

  typedef enum logic [2:0] {
    POS_START,
    POS_HDR_SPACE,
    POS_BIT_MARK,
    POS_BIT_SPACE,
    POS_TRL_MARK,
    POS_TRL_SPACE
  } irpd_pos_t;

endpackage

FILE: sv/ir_pulse_distance_frame_encoder_unit.sv
// Pulse-distance infrared frame encoder.
// Input channel: one transaction carries a frame byte plus first/last flags.
// It is taken at a rising edge with in_push high and in_full low. A first byte
// is preceded by a header mark and space; the byte follows as eight mark/space
// pairs, least significant bit first; a last byte is followed by a trailer.
// Result channel: each transaction is one pulse (level, duration in us); the
// final pulse caused by an input byte has out_last_pulse set. The oldest pulse
// is on the out_ ports while out_empty is low and leaves at an edge with
// out_pop high. The first pulse of a byte is registered once the byte is queued
// and the output register is free. An item yields 16 to 20 pulses, one per
// cycle while the receiver pops each one; the stream runs without gaps across
// bytes. A two-entry queue in front of the sequencer keeps taking bytes while it
// works. When the receiver stalls, the held pulse stays put and the sequencer
// waits; once the queue fills, in_full rises. Reset (synchronous, active low)
// empties the queue and the output register and loads the default durations.
// Durations are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while idle, unenforced by the block; unknown indexes are ignored.
module ir_pulse_distance_frame_encoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [irpd_pkg::DATA_W-1:0]         in_data_byte,
  input  logic                                in_first_byte,
  input  logic                                in_last_byte,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_pulse_level,
  output logic [irpd_pkg::DUR_W-1:0]          out_duration_us,
  output logic                                out_last_pulse,
  input  logic                                cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irpd_pkg::DUR_W-1:0]          cfg_data
);
  import irpd_pkg::*;

`include "assert_macros.svh"

  irpd_cfg_t        cfg_r;
  irpd_cmd_t        in_cmd;
  irpd_cmd_t        head_cmd;
  irpd_q_status_t   q_status;
  irpd_seq_status_t seq_status;
  logic             q_pop;

  // Duration registers, one per configuration index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_mark  <= HEADER_MARK_RST;
      cfg_r.header_space <= HEADER_SPACE_RST;
      cfg_r.one_mark     <= ONE_MARK_RST;
      cfg_r.one_space    <= ONE_SPACE_RST;
      cfg_r.zero_mark    <= ZERO_MARK_RST;
      cfg_r.zero_space   <= ZERO_SPACE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_MARK:  cfg_r.header_mark  <= cfg_data;
        REG_HEADER_SPACE: cfg_r.header_space <= cfg_data;
        REG_ONE_MARK:     cfg_r.one_mark     <= cfg_data;
        REG_ONE_SPACE:    cfg_r.one_space    <= cfg_data;
        REG_ZERO_MARK:    cfg_r.zero_mark    <= cfg_data;
        REG_ZERO_SPACE:   cfg_r.zero_space   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_cmd.data  = in_data_byte;
  assign in_cmd.first = in_first_byte;
  assign in_cmd.last  = in_last_byte;
  assign in_full      = q_status.full;

  // Front: queues accepted bytes as commands for the sequencer.
  irpd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .cmd_in (in_cmd),
    .pop    (q_pop),
    .cmd_out(head_cmd),
    .status (q_status)
  );

  // Back: walks header, bits and trailer of the head command, one pulse
  // per cycle unless the output stalls, and retires the command with its final pulse.
  irpd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (head_cmd),
    .cmd_valid      (!q_status.empty),
    .cmd_pop        (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_pulse_level(out_pulse_level),
    .out_duration_us(out_duration_us),
    .out_last_pulse (out_last_pulse),
    .status         (seq_status)
  );

  // The sequencer retires a command only with a pulse flagged as its last.
  `ASSERT_IMPLIES(a_pop_on_last, q_pop, seq_status.emit && seq_status.last_pulse)
  // The sequencer never retires from an empty queue.
  `ASSERT_IMPLIES(a_pop_nonempty, q_pop, !q_status.empty)
  // An accepted byte cannot leave the queue in the same cycle it enters.
  `ASSERT_NEXT(a_push_holds, in_push && !in_full, !q_status.empty)
  // The queue only fills as a result of an accepted transaction.
  `ASSERT_IMPLIES(a_full_after_push, $rose(in_full), $past(in_push))

endmodule

FILE: sv/irpd_front.sv
module irpd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  irpd_pkg::irpd_cmd_t     cmd_in,
  input  logic                    pop,
  output irpd_pkg::irpd_cmd_t     cmd_out,
  output irpd_pkg::irpd_q_status_t status
);
  import irpd_pkg::*;

  irpd_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QCNT_W-1:0]  cnt_nxt;
  logic               wr_en;
  logic               rd_en;

  assign status.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign wr_en        = push && !status.full;
  assign rd_en        = pop && !status.empty;
  assign cmd_out      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: sv/irpd_back.sv
module irpd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  irpd_pkg::irpd_cfg_t         cfg,
  input  irpd_pkg::irpd_cmd_t         cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic                        out_pulse_level,
  output logic [irpd_pkg::DUR_W-1:0]  out_duration_us,
  output logic                        out_last_pulse,
  output irpd_pkg::irpd_seq_status_t  status
);
  import irpd_pkg::*;

  irpd_pos_t             pos_r;
  irpd_pos_t             pos_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r;
  logic [BIT_CNT_W-1:0]  bit_cnt_nxt;
  logic                  valid_r;
  logic                  level_r;
  logic [DUR_W-1:0]      dur_r;
  logic                  last_r;
  logic                  level_nxt;
  logic [DUR_W-1:0]      dur_nxt;
  logic                  last_nxt;
  logic [DATA_W-1:0]     shifted;
  logic                  cur_bit;
  logic                  emit;

  // Bit positions past the data field shift in zeros and go out as zero bits.
  assign shifted = cmd.data >> bit_cnt_r;
  assign cur_bit = shifted[0];
  assign emit    = cmd_valid && (!valid_r || out_pop);

  always_comb begin
    level_nxt   = 1'b1;
    dur_nxt     = cfg.zero_mark;
    last_nxt    = 1'b0;
    pos_nxt     = pos_r;
    bit_cnt_nxt = bit_cnt_r;
    case (pos_r)
      POS_START: begin
        if (cmd.first) begin
          dur_nxt = cfg.header_mark;
          pos_nxt = POS_HDR_SPACE;
        end else begin
          dur_nxt = cur_bit ? cfg.one_mark : cfg.zero_mark;
          pos_nxt = POS_BIT_SPACE;
        end
      end
      POS_HDR_SPACE: begin
        level_nxt = 1'b0;
        dur_nxt   = cfg.header_space;
        pos_nxt   = POS_BIT_MARK;
      end
      POS_BIT_MARK: begin
        dur_nxt = cur_bit ? cfg.one_mark : cfg.zero_mark;
        pos_nxt = POS_BIT_SPACE;
      end
      POS_BIT_SPACE: begin
        level_nxt = 1'b0;
        dur_nxt   = cur_bit ? cfg.one_space : cfg.zero_space;
        if (bit_cnt_r == BIT_CNT_W'(BITS_PER_ITEM - 1)) begin
          bit_cnt_nxt = '0;
          if (cmd.last) begin
            pos_nxt = POS_TRL_MARK;
          end else begin
            last_nxt = 1'b1;
            pos_nxt  = POS_START;
          end
        end else begin
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          pos_nxt     = POS_BIT_MARK;
        end
      end
      POS_TRL_MARK: begin
        dur_nxt = cfg.one_mark;
        pos_nxt = POS_TRL_SPACE;
      end
      POS_TRL_SPACE: begin
        level_nxt = 1'b0;
        dur_nxt   = cfg.zero_space;
        last_nxt  = 1'b1;
        pos_nxt   = POS_START;
      end
      default: begin
        pos_nxt     = POS_START;
        bit_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_START;
      bit_cnt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (emit) begin
        pos_r     <= pos_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        valid_r   <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      level_r <= level_nxt;
      dur_r   <= dur_nxt;
      last_r  <= last_nxt;
    end
  end

  assign cmd_pop           = emit && last_nxt;
  assign out_empty         = !valid_r;
  assign out_pulse_level   = level_r;
  assign out_duration_us   = dur_r;
  assign out_last_pulse    = last_r;
  assign status.emit       = emit;
  assign status.last_pulse = last_nxt;

endmodule
